@@ rtl/hc2_pkg.sv @@
// ----------------------------------------------------------------------------
// hc2_pkg
// Types, constants and small mod-26 helpers shared by the 2x2 Hill cipher.
// ----------------------------------------------------------------------------
package hc2_pkg;

  // Alphabet size, the pad letter X, and the width of one letter.
  localparam int unsigned LETTER_W = 5;
  localparam int unsigned PROD_W   = 2 * LETTER_W;
  localparam int unsigned SUM_W    = PROD_W + 1;
  localparam logic [LETTER_W-1:0] LETTERS    = 5'd26;
  localparam logic [LETTER_W-1:0] PAD_LETTER = 5'd23;

  // Key register reset values.
  localparam logic [LETTER_W-1:0] KEY00_RST = 5'd6;
  localparam logic [LETTER_W-1:0] KEY01_RST = 5'd24;
  localparam logic [LETTER_W-1:0] KEY10_RST = 5'd1;
  localparam logic [LETTER_W-1:0] KEY11_RST = 5'd13;

  typedef logic [LETTER_W-1:0] letter_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_KEY00 = 3'd0,
    REG_KEY01 = 3'd1,
    REG_KEY10 = 3'd2,
    REG_KEY11 = 3'd3,
    REG_MODE  = 3'd4
  } cfg_reg_t;

  // One letter pair waiting to be transformed.
  typedef struct packed {
    logic    last;
    letter_t p1;
    letter_t p0;
  } pair_t;

  // Working matrix handed from the key unit to the datapath.
  typedef struct packed {
    logic    ready;
    logic    err;
    letter_t m00;
    letter_t m01;
    letter_t m10;
    letter_t m11;
  } key_t;

  // Reduce a 5-bit value into 0..25 with one compare and subtract.
  function automatic letter_t red_letter(input letter_t v);
    return (v >= LETTERS) ? letter_t'(v - LETTERS) : v;
  endfunction

  // Value mod 26 for an 11-bit value: reciprocal multiply, then subtract q*26.
  // The reciprocal 2521/65536 is exact enough over the whole 11-bit range.
  function automatic letter_t mod26(input logic [SUM_W-1:0] v);
    logic [SUM_W+11:0] prod;
    logic [6:0]        q;
    logic [SUM_W-1:0]  qw;
    logic [SUM_W-1:0]  qm;
    logic [SUM_W-1:0]  r;
    prod = {12'd0, v} * 23'd2521;
    q    = prod[22:16];
    qw   = {4'd0, q};
    qm   = (qw << 4) + (qw << 3) + (qw << 1);
    r    = v - qm;
    return r[LETTER_W-1:0];
  endfunction

  // Multiplicative inverse modulo 26, zero when none exists.
  function automatic letter_t inv26(input letter_t v);
    letter_t r;
    unique case (v)
      5'd1:    r = 5'd1;
      5'd3:    r = 5'd9;
      5'd5:    r = 5'd21;
      5'd7:    r = 5'd15;
      5'd9:    r = 5'd3;
      5'd11:   r = 5'd19;
      5'd15:   r = 5'd7;
      5'd17:   r = 5'd23;
      5'd19:   r = 5'd11;
      5'd21:   r = 5'd5;
      5'd23:   r = 5'd17;
      5'd25:   r = 5'd25;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/hc2_front.sv @@
// ----------------------------------------------------------------------------
// hc2_front
// Accepts letters, pairs them up and pads a lone final letter with X.
// ----------------------------------------------------------------------------
module hc2_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [4:0] in_letter, [7:5] zero
  input  logic              in_tlast,   // in_last
  input  logic              q_full,
  output logic              push,
  output hc2_pkg::pair_t    push_pair
);
  import hc2_pkg::*;

  letter_t held_r, held_nxt;
  logic    holding_r, holding_nxt;
  letter_t letter;
  logic    accept;

  // Take a letter whenever the queue has room.
  assign in_tready = ~q_full;
  assign accept    = in_tvalid & in_tready;
  assign letter    = red_letter(in_tdata[LETTER_W-1:0]);

  // A pair is complete on a second letter or on a lone final letter.
  assign push = accept & (holding_r | in_tlast);

  always_comb begin
    if (holding_r) begin
      push_pair = '{last: in_tlast, p1: letter, p0: held_r};
    end else begin
      push_pair = '{last: 1'b1, p1: PAD_LETTER, p0: letter};
    end
  end

  // Track the first letter of an open pair.
  always_comb begin
    held_nxt    = held_r;
    holding_nxt = holding_r;
    if (accept) begin
      if (holding_r) begin
        held_nxt    = '0;
        holding_nxt = 1'b0;
      end else if (!in_tlast) begin
        held_nxt    = letter;
        holding_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r    <= '0;
      holding_r <= 1'b0;
    end else begin
      held_r    <= held_nxt;
      holding_r <= holding_nxt;
    end
  end

endmodule

@@ rtl/hc2_fifo.sv @@
// ----------------------------------------------------------------------------
// hc2_fifo
// Short queue of letter pairs between the front end and the datapath.
// ----------------------------------------------------------------------------
module hc2_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  hc2_pkg::pair_t push_pair,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output hc2_pkg::pair_t head
);
  import hc2_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  pair_t            mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == FULL_CNT);
  assign valid = (count_r != '0);
  assign head  = mem_r[rd_ptr_r];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_pair;
    end
  end

endmodule

@@ rtl/hc2_keygen.sv @@
// ----------------------------------------------------------------------------
// hc2_keygen
// Holds the key and mode registers and derives the working matrix in four
// registered steps: products, determinant inverse, scaled adjugate, mod 26.
// ----------------------------------------------------------------------------
module hc2_keygen (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [4:0]  cfg_wdata,
  output hc2_pkg::key_t key
);
  import hc2_pkg::*;

  // Cycles from a register change until the matrix reflects it.
  localparam logic [2:0] SETTLE = 3'd4;

  letter_t k00_r, k01_r, k10_r, k11_r;
  logic    mode_r;
  logic [2:0] settle_r;

  // Step 1: reduced keys and determinant products.
  letter_t           s1_a_r, s1_b_r, s1_c_r, s1_d_r;
  logic [PROD_W-1:0] s1_ad_r, s1_bc_r;
  logic              s1_mode_r;
  letter_t           ra, rb, rc, rd;

  // Step 2: determinant inverse and negated off-diagonal terms.
  letter_t           s2_a_r, s2_b_r, s2_c_r, s2_d_r;
  letter_t           s2_nb_r, s2_nc_r, s2_dinv_r;
  logic              s2_mode_r;
  logic [SUM_W-1:0]  det_sum;

  // Step 3: adjugate scaled by the inverse.
  letter_t           s3_a_r, s3_b_r, s3_c_r, s3_d_r;
  logic [PROD_W-1:0] s3_p00_r, s3_p01_r, s3_p10_r, s3_p11_r;
  logic              s3_mode_r, s3_err_r;

  // Step 4: final matrix.
  letter_t m00_r, m01_r, m10_r, m11_r;
  logic    err_r;

  // Configuration registers and the settle counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k00_r    <= KEY00_RST;
      k01_r    <= KEY01_RST;
      k10_r    <= KEY10_RST;
      k11_r    <= KEY11_RST;
      mode_r   <= 1'b0;
      settle_r <= SETTLE;
    end else if (cfg_we) begin
      settle_r <= SETTLE;
      unique case (cfg_reg_t'(cfg_index))
        REG_KEY00: k00_r  <= cfg_wdata;
        REG_KEY01: k01_r  <= cfg_wdata;
        REG_KEY10: k10_r  <= cfg_wdata;
        REG_KEY11: k11_r  <= cfg_wdata;
        REG_MODE:  mode_r <= cfg_wdata[0];
        default: ;
      endcase
    end else if (settle_r != '0) begin
      settle_r <= settle_r - 1'b1;
    end
  end

  assign ra = red_letter(k00_r);
  assign rb = red_letter(k01_r);
  assign rc = red_letter(k10_r);
  assign rd = red_letter(k11_r);

  // Adding 676 keeps the determinant difference non-negative.
  assign det_sum = {1'b0, s1_ad_r} + SUM_W'(676) - {1'b0, s1_bc_r};

  // Derivation pipeline runs every cycle from the current registers.
  always_ff @(posedge clk) begin
    s1_a_r    <= ra;
    s1_b_r    <= rb;
    s1_c_r    <= rc;
    s1_d_r    <= rd;
    s1_ad_r   <= {5'd0, ra} * {5'd0, rd};
    s1_bc_r   <= {5'd0, rb} * {5'd0, rc};
    s1_mode_r <= mode_r;

    s2_a_r    <= s1_a_r;
    s2_b_r    <= s1_b_r;
    s2_c_r    <= s1_c_r;
    s2_d_r    <= s1_d_r;
    s2_nb_r   <= (s1_b_r == '0) ? '0 : letter_t'(LETTERS - s1_b_r);
    s2_nc_r   <= (s1_c_r == '0) ? '0 : letter_t'(LETTERS - s1_c_r);
    s2_dinv_r <= inv26(mod26(det_sum));
    s2_mode_r <= s1_mode_r;

    s3_a_r    <= s2_a_r;
    s3_b_r    <= s2_b_r;
    s3_c_r    <= s2_c_r;
    s3_d_r    <= s2_d_r;
    s3_p00_r  <= {5'd0, s2_d_r}  * {5'd0, s2_dinv_r};
    s3_p01_r  <= {5'd0, s2_nb_r} * {5'd0, s2_dinv_r};
    s3_p10_r  <= {5'd0, s2_nc_r} * {5'd0, s2_dinv_r};
    s3_p11_r  <= {5'd0, s2_a_r}  * {5'd0, s2_dinv_r};
    s3_mode_r <= s2_mode_r;
    s3_err_r  <= s2_mode_r & (s2_dinv_r == '0);

    m00_r <= s3_mode_r ? mod26({1'b0, s3_p00_r}) : s3_a_r;
    m01_r <= s3_mode_r ? mod26({1'b0, s3_p01_r}) : s3_b_r;
    m10_r <= s3_mode_r ? mod26({1'b0, s3_p10_r}) : s3_c_r;
    m11_r <= s3_mode_r ? mod26({1'b0, s3_p11_r}) : s3_d_r;
    err_r <= s3_err_r;
  end

  assign key = '{ready: (settle_r == '0), err: err_r,
                 m00: m00_r, m01: m01_r, m10: m10_r, m11: m11_r};

endmodule

@@ rtl/hc2_back.sv @@
// ----------------------------------------------------------------------------
// hc2_back
// Transforms queued pairs: multiply stage, sum and mod-26 stage, then an
// output register that emits the two letters of each pair in turn.
// ----------------------------------------------------------------------------
module hc2_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  hc2_pkg::pair_t q_head,
  output logic           pop,
  input  hc2_pkg::key_t  key,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [7:0]     out_tdata,  // [4:0] out_letter, [7:5] zero
  output logic           out_tlast,  // out_last
  output logic           out_tuser   // key_error
);
  import hc2_pkg::*;

  // Multiply stage.
  logic              s1_v_r;
  logic [PROD_W-1:0] s1_p00_r, s1_p01_r, s1_p10_r, s1_p11_r;
  letter_t           s1_l0_r, s1_l1_r;
  logic              s1_last_r, s1_err_r;

  // Sum and reduce stage.
  logic    s2_v_r;
  letter_t s2_c0_r, s2_c1_r;
  logic    s2_last_r, s2_err_r;

  // Output register.
  logic    buf_v_r, buf_v_nxt;
  logic    phase_r, phase_nxt;
  letter_t buf_c0_r, buf_c1_r;
  logic    buf_last_r, buf_err_r;

  logic s1_ready, s2_ready, buf_load;
  logic out_accept;

  // The output register frees once the second letter is taken.
  assign out_accept = out_tvalid & out_tready;
  assign buf_load   = ~buf_v_r | (phase_r & out_tready);
  assign s2_ready   = ~s2_v_r | buf_load;
  assign s1_ready   = ~s1_v_r | s2_ready;
  assign pop        = q_valid & key.ready & s1_ready;

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_r <= pop;
      end
      if (s2_ready) begin
        s2_v_r <= s1_v_r;
      end
    end
  end

  // Products of the matrix and the pair.
  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_p00_r  <= {5'd0, key.m00} * {5'd0, q_head.p0};
      s1_p01_r  <= {5'd0, key.m01} * {5'd0, q_head.p1};
      s1_p10_r  <= {5'd0, key.m10} * {5'd0, q_head.p0};
      s1_p11_r  <= {5'd0, key.m11} * {5'd0, q_head.p1};
      s1_l0_r   <= q_head.p0;
      s1_l1_r   <= q_head.p1;
      s1_last_r <= q_head.last;
      s1_err_r  <= key.err;
    end
  end

  // Row sums reduced mod 26; a bad key passes the letters through.
  always_ff @(posedge clk) begin
    if (s2_ready) begin
      s2_c0_r   <= s1_err_r ? s1_l0_r : mod26({1'b0, s1_p00_r} + {1'b0, s1_p01_r});
      s2_c1_r   <= s1_err_r ? s1_l1_r : mod26({1'b0, s1_p10_r} + {1'b0, s1_p11_r});
      s2_last_r <= s1_last_r;
      s2_err_r  <= s1_err_r;
    end
  end

  // Serializer control: first letter, then second.
  always_comb begin
    buf_v_nxt = buf_v_r;
    phase_nxt = phase_r;
    if (buf_load) begin
      buf_v_nxt = s2_v_r;
      phase_nxt = 1'b0;
    end else if (out_accept) begin
      phase_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_v_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      buf_v_r <= buf_v_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (buf_load) begin
      buf_c0_r   <= s2_c0_r;
      buf_c1_r   <= s2_c1_r;
      buf_last_r <= s2_last_r;
      buf_err_r  <= s2_err_r;
    end
  end

  assign out_tvalid = buf_v_r;
  assign out_tdata  = {3'd0, phase_r ? buf_c1_r : buf_c0_r};
  assign out_tlast  = phase_r & buf_last_r;
  assign out_tuser  = buf_err_r;

endmodule

@@ rtl/hill_cipher_2x2_mod26_unit.sv @@
// ----------------------------------------------------------------------------
// hill_cipher_2x2_mod26_unit
// 2x2 Hill cipher over the letters 0..25, encrypt or decrypt.
// ----------------------------------------------------------------------------
// Letters enter on the in_ stream, one per item, with in_tlast on the final
// letter of a message. Letters are paired; a lone final letter is padded with
// X. Each pair leaves on the out_ stream as two items, first then second,
// with out_tlast on the second item of the final pair and out_tuser set when
// decrypting with a key whose determinant has no inverse mod 26 (the letters
// then pass through unchanged).
// Registers are written on the cfg_ port: index 0..3 are the key entries by
// row, index 4 selects decrypt. The working matrix is derived in a four-step
// key pipeline; after reset or a register write, pairs wait until it settles.
// Throughput is one letter per cycle in and out unless the receiver stalls or
// the key is settling. The item that completes a pair passes through the pair
// queue, then the multiply, reduce and output register stages, to the output.
// A stalled receiver holds the output register; the pair queue keeps taking
// letters until it fills, then in_tready drops. Reset clears all control
// state and restores the default key.
// ----------------------------------------------------------------------------
module hill_cipher_2x2_mod26_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [4:0] in_letter, [7:5] zero
  input  logic       in_tlast,   // in_last
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [4:0] out_letter, [7:5] zero
  output logic       out_tlast,  // out_last
  output logic       out_tuser,  // key_error
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [4:0] cfg_wdata
);
  import hc2_pkg::*;

  logic  push, pop, q_full, q_valid;
  pair_t push_pair, q_head;
  key_t  key;

  hc2_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .push      (push),
    .push_pair (push_pair)
  );

  hc2_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_pair (push_pair),
    .full      (q_full),
    .pop       (pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  hc2_keygen u_keygen (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .key       (key)
  );

  hc2_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .pop        (pop),
    .key        (key),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

@@ bench/hill_cipher_2x2_mod26_unit_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hill_cipher_2x2_mod26_unit_test
// Self-checking bench for the 2x2 mod-26 Hill cipher unit.
// ----------------------------------------------------------------------------
// Letters go in as stream items and are also fed to a predictor of the
// pairing, the padding and the mod-26 matrix products. Every output item is
// checked against the oldest predicted letter. Short directed tests cover the
// default key, extreme and out-of-range keys and letters, non-invertible
// decrypt keys, key changes while a letter is held, and writes to unused
// register indexes. Randomized messages follow under three stall profiles.
// ----------------------------------------------------------------------------
module hill_cipher_2x2_mod26_unit_test;
  import hc2_pkg::*;

  localparam int unsigned ALPHABET     = LETTERS;
  localparam int unsigned RESET_CYCLES = 12;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned SEG_ITEMS    = 157;
  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam logic [2:0]  SPARE_INDEX_LO = 3'd5;
  localparam int unsigned SPARE_COUNT    = 3;

  // One expected output item.
  typedef struct {
    letter_t letter;
    logic    last;
    logic    err;
  } cipher_out_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'd0;   // [4:0] in_letter, [7:5] zero
  logic       in_tlast = 1'b0;   // in_last
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;         // [4:0] out_letter, [7:5] zero
  logic       out_tlast;         // out_last
  logic       out_tuser;         // key_error
  logic       cfg_we = 1'b0;
  logic [2:0] cfg_index = 3'd0;
  logic [4:0] cfg_wdata = 5'd0;

  // Predictor state: key, mode and the open pair.
  letter_t key_model [4];
  logic    decrypt_model;
  letter_t held_letter;
  bit      holding_first;

  cipher_out_t expected_letters [$];
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned cycle_count = 0;
  int          errors = 0;

  hill_cipher_2x2_mod26_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d letters outstanding", $time, expected_letters.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver stalls at the current rate.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Compare each accepted output item with the oldest prediction.
  always @(posedge clk) begin
    cipher_out_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_letters.size() == 0) begin
        errors++;
        $display("%0t: unexpected letter, expected none, actual letter %0d last %0b err %0b",
                 $time, out_tdata, out_tlast, out_tuser);
      end else begin
        want = expected_letters.pop_front();
        if (out_tdata !== {3'b000, want.letter} || out_tlast !== want.last ||
            out_tuser !== want.err) begin
          errors++;
          $display("%0t: mismatch, expected %0d last %0b err %0b, actual %0d last %0b err %0b",
                   $time, want.letter, want.last, want.err, out_tdata, out_tlast, out_tuser);
        end
      end
    end
  end

  // Multiplicative inverse modulo 26, zero when none exists.
  function automatic int unsigned inv_mod26(input int unsigned v);
    for (int unsigned i = 1; i < ALPHABET; i++) begin
      if ((v * i) % ALPHABET == 1) return i;
    end
    return 0;
  endfunction

  // Determinant of a key (raw register values) modulo 26.
  function automatic int unsigned key_det(input letter_t k00, input letter_t k01,
                                          input letter_t k10, input letter_t k11);
    int unsigned a;
    int unsigned b;
    int unsigned c;
    int unsigned d;
    a = k00 % ALPHABET;
    b = k01 % ALPHABET;
    c = k10 % ALPHABET;
    d = k11 % ALPHABET;
    return (a * d + ALPHABET * ALPHABET - b * c) % ALPHABET;
  endfunction

  task automatic push_letter(input int unsigned letter, input logic last, input logic err);
    cipher_out_t r;
    r.letter = letter_t'(letter);
    r.last   = last;
    r.err    = err;
    expected_letters.push_back(r);
  endtask

  // Expected output for one completed pair under the key now in force.
  task automatic predict_pair(input int unsigned p0, input int unsigned p1, input logic last);
    int unsigned m00;
    int unsigned m01;
    int unsigned m10;
    int unsigned m11;
    int unsigned dinv;
    m00 = key_model[0] % ALPHABET;
    m01 = key_model[1] % ALPHABET;
    m10 = key_model[2] % ALPHABET;
    m11 = key_model[3] % ALPHABET;
    if (decrypt_model) begin
      dinv = inv_mod26(key_det(key_model[0], key_model[1], key_model[2], key_model[3]));
      if (dinv == 0) begin
        // No inverse key: the pair passes through flagged.
        push_letter(p0, 1'b0, 1'b1);
        push_letter(p1, last, 1'b1);
        return;
      end
      // Inverse key is the adjugate scaled by the determinant's inverse.
      {m00, m11} = {(m11 * dinv) % ALPHABET, (m00 * dinv) % ALPHABET};
      m01 = (((ALPHABET - m01) % ALPHABET) * dinv) % ALPHABET;
      m10 = (((ALPHABET - m10) % ALPHABET) * dinv) % ALPHABET;
    end
    push_letter((m00 * p0 + m01 * p1) % ALPHABET, 1'b0, 1'b0);
    push_letter((m10 * p0 + m11 * p1) % ALPHABET, last, 1'b0);
  endtask

  // Pairing and padding of one accepted input letter.
  task automatic predict_letter(input letter_t raw, input logic last);
    int unsigned v;
    v = raw % ALPHABET;
    if (holding_first) begin
      holding_first = 1'b0;
      predict_pair(held_letter, v, last);
      held_letter = '0;
    end else if (last) begin
      predict_pair(v, PAD_LETTER, 1'b1);
    end else begin
      held_letter   = letter_t'(v);
      holding_first = 1'b1;
    end
  endtask

  // Send one letter, idling first at the sender's rate.
  task automatic send_letter(input letter_t letter, input logic last);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, letter};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    predict_letter(letter, last);
  endtask

  // Stop sending, wait for every expected letter, then let the pipeline settle.
  task automatic drain_block();
    in_tvalid <= 1'b0;
    while (expected_letters.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One register write; cfg_we is left high for back-to-back writes.
  task automatic write_reg(input logic [2:0] idx, input logic [4:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      REG_KEY00: key_model[0] = value;
      REG_KEY01: key_model[1] = value;
      REG_KEY10: key_model[2] = value;
      REG_KEY11: key_model[3] = value;
      REG_MODE:  decrypt_model = value[0];
      default: ;
    endcase
  endtask

  task automatic set_cipher(input letter_t k00, input letter_t k01, input letter_t k10,
                            input letter_t k11, input logic decrypt);
    write_reg(REG_KEY00, k00);
    write_reg(REG_KEY01, k01);
    write_reg(REG_KEY10, k10);
    write_reg(REG_KEY11, k11);
    write_reg(REG_MODE, {4'b0000, decrypt});
    cfg_we <= 1'b0;
  endtask

  // Reset key, encrypt: plain pairs, out-of-range letters, a lone last letter.
  task automatic test_default_key();
    send_letter(5'd0, 1'b0);
    send_letter(5'd25, 1'b0);
    send_letter(5'd31, 1'b0);
    send_letter(5'd26, 1'b1);
    send_letter(5'd7, 1'b1);
  endtask

  // Keys at and beyond the range ends, invertible and not, in both modes.
  task automatic test_key_extremes();
    drain_block();
    set_cipher(5'd31, 5'd31, 5'd31, 5'd31, 1'b0);
    send_letter(5'd25, 1'b0);
    send_letter(5'd0, 1'b1);
    drain_block();
    set_cipher(5'd0, 5'd0, 5'd0, 5'd0, 1'b1);
    send_letter(5'd30, 1'b0);
    send_letter(5'd1, 1'b1);
    send_letter(5'd12, 1'b1);
    drain_block();
    set_cipher(5'd25, 5'd0, 5'd0, 5'd25, 1'b1);
    send_letter(5'd17, 1'b0);
    send_letter(5'd4, 1'b1);
    drain_block();
    set_cipher(5'd27, 5'd0, 5'd0, 5'd29, 1'b1);
    send_letter(5'd9, 1'b1);
  endtask

  // The key in force when a pair completes applies to the whole pair.
  task automatic test_held_letter_across_write();
    drain_block();
    send_letter(5'd3, 1'b0);
    drain_block();
    set_cipher(5'd3, 5'd3, 5'd2, 5'd5, 1'b0);
    send_letter(5'd19, 1'b1);
  endtask

  // Writes to indexes past the mode register change nothing.
  task automatic test_spare_indexes();
    drain_block();
    for (int unsigned i = 0; i < SPARE_COUNT; i++) begin
      write_reg(SPARE_INDEX_LO + 3'(i), 5'd31);
    end
    cfg_we <= 1'b0;
    send_letter(5'd2, 1'b0);
    send_letter(5'd24, 1'b1);
  endtask

  // Random messages under a random key; decrypt keys may be forced invertible.
  task automatic random_segment(input logic decrypt, input bit need_inverse);
    letter_t     k [4];
    int unsigned sent;
    int unsigned len;
    drain_block();
    do begin
      foreach (k[i]) begin
        k[i] = ($urandom_range(7) == 0) ? letter_t'($urandom_range(31, 26))
                                        : letter_t'($urandom_range(25));
      end
    end while (decrypt && need_inverse && inv_mod26(key_det(k[0], k[1], k[2], k[3])) == 0);
    set_cipher(k[0], k[1], k[2], k[3], decrypt);
    sent = 0;
    while (sent < SEG_ITEMS) begin
      len = $urandom_range(9, 1);
      for (int unsigned i = 0; i < len; i++) begin
        send_letter(($urandom_range(9) == 0) ? letter_t'($urandom_range(31, 26))
                                             : letter_t'($urandom_range(25)),
                    i == len - 1);
        sent++;
      end
    end
  endtask

  task automatic test_idle_profile(input int unsigned tx_pct, input int unsigned rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    random_segment(1'b0, 1'b0);
    random_segment(1'b1, 1'b1);
    random_segment(1'b1, 1'b0);
  endtask

  // Test sequence.
  initial begin
    key_model     = '{KEY00_RST, KEY01_RST, KEY10_RST, KEY11_RST};
    decrypt_model = 1'b0;
    held_letter   = '0;
    holding_first = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    test_default_key();
    test_key_extremes();
    test_held_letter_across_write();
    test_spare_indexes();
    test_idle_profile(20, 54);
    test_idle_profile(54, 20);
    test_idle_profile(0, 0);
    drain_block();
    if (errors == 0 && expected_letters.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
